// ----- hw/rtl/vt4_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vt4_pkg
// Shared types and fixed field widths for the 4x4 vertex transform.
// ----------------------------------------------------------------------------
package vt4_pkg;

    // matrix geometry
    localparam int MAT_DIM     = 4;
    localparam int NUM_COEFFS  = MAT_DIM * MAT_DIM;
    localparam int COEFF_IDX_W = $clog2(NUM_COEFFS);

    // fixed port field widths
    localparam int ACTION_W = 2;
    localparam int FIELD_W  = 32;

    // item action codes, code 3 is unused
    typedef enum logic [ACTION_W-1:0] {
        ACT_LOAD   = 2'd0,
        ACT_POINT  = 2'd1,
        ACT_VECTOR = 2'd2
    } action_t;

    // control that travels with the product terms
    typedef struct packed {
        logic valid;
        logic has_w;
    } stage_ctrl_t;

endpackage

// ----- hw/rtl/vt4_coeff_bank.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vt4_coeff_bank
// Sixteen coefficient registers, column-major, one write port, all taps out.
// ----------------------------------------------------------------------------
module vt4_coeff_bank #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                wr_en,
    input  logic [vt4_pkg::COEFF_IDX_W-1:0]     wr_idx,
    input  logic signed [DATA_WIDTH-1:0]        wr_data,
    output logic signed [DATA_WIDTH-1:0]        coeff [vt4_pkg::NUM_COEFFS]
);

    logic signed [DATA_WIDTH-1:0] coeff_reg [vt4_pkg::NUM_COEFFS];

    // coefficient storage, cleared by reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < vt4_pkg::NUM_COEFFS; i++) begin
                coeff_reg[i] <= '0;
            end
        end else if (wr_en) begin
            coeff_reg[wr_idx] <= wr_data;
        end
    end

    assign coeff = coeff_reg;

endmodule

// ----- hw/rtl/vt4_product_stage.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vt4_product_stage
// Sixteen parallel fixed-point products, floored by the fraction shift.
// ----------------------------------------------------------------------------
module vt4_product_stage #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              load_en,
    input  logic                              in_xform,
    input  logic                              in_point,
    input  logic signed [DATA_WIDTH-1:0]      vec   [vt4_pkg::MAT_DIM],
    input  logic signed [DATA_WIDTH-1:0]      coeff [vt4_pkg::NUM_COEFFS],
    output vt4_pkg::stage_ctrl_t              ctrl,
    output logic signed [2*DATA_WIDTH-1:0]    term  [vt4_pkg::MAT_DIM][vt4_pkg::MAT_DIM]
);

    localparam int TERM_W = 2 * DATA_WIDTH;

    logic                     valid_reg;
    logic                     has_w_reg;
    logic signed [TERM_W-1:0] term_reg  [vt4_pkg::MAT_DIM][vt4_pkg::MAT_DIM];
    logic signed [TERM_W-1:0] term_next [vt4_pkg::MAT_DIM][vt4_pkg::MAT_DIM];
    logic signed [TERM_W-1:0] prod      [vt4_pkg::MAT_DIM][vt4_pkg::MAT_DIM];

    // row r, column c term: m[c][r] * v[c] floored; translation for points
    always_comb begin
        for (int r = 0; r < vt4_pkg::MAT_DIM; r++) begin
            for (int c = 0; c < vt4_pkg::MAT_DIM; c++) begin
                prod[r][c] = coeff[c*vt4_pkg::MAT_DIM + r] * vec[c];
                term_next[r][c] = prod[r][c] >>> FRAC_BITS;
            end
            if (in_point) begin
                term_next[r][vt4_pkg::MAT_DIM-1] =
                    TERM_W'(coeff[(vt4_pkg::MAT_DIM-1)*vt4_pkg::MAT_DIM + r]);
            end
        end
    end

    // stage valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load_en) begin
            valid_reg <= in_xform;
        end
    end

    // product registers
    always_ff @(posedge aclk) begin
        if (load_en && in_xform) begin
            has_w_reg <= !in_point;
            term_reg  <= term_next;
        end
    end

    assign ctrl.valid = valid_reg;
    assign ctrl.has_w = has_w_reg;
    assign term       = term_reg;

endmodule

// ----- hw/rtl/vt4_accum_stage.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vt4_accum_stage
// Row sums of the product terms, saturation, and the result register.
// ----------------------------------------------------------------------------
module vt4_accum_stage #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              load_en,
    input  vt4_pkg::stage_ctrl_t              ctrl,
    input  logic signed [2*DATA_WIDTH-1:0]    term [vt4_pkg::MAT_DIM][vt4_pkg::MAT_DIM],
    output logic                              out_valid,
    output logic [vt4_pkg::FIELD_W-1:0]       out_comp [vt4_pkg::MAT_DIM],
    output logic                              out_has_w,
    output logic                              out_overflow
);

    localparam int TERM_W = 2 * DATA_WIDTH;
    localparam int SUM_W  = TERM_W + 2;
    localparam int HEAD_W = SUM_W - DATA_WIDTH + 1;

    logic signed [SUM_W-1:0]      row_sum [vt4_pkg::MAT_DIM];
    logic [HEAD_W-1:0]            head    [vt4_pkg::MAT_DIM];
    logic [DATA_WIDTH-1:0]        sat_val [vt4_pkg::MAT_DIM];
    logic [vt4_pkg::MAT_DIM-1:0]  sat_hit;
    logic [vt4_pkg::FIELD_W-1:0]  comp_next [vt4_pkg::MAT_DIM];
    logic                         ovf_next;

    logic                         valid_reg;
    logic                         has_w_reg;
    logic                         ovf_reg;
    logic [vt4_pkg::FIELD_W-1:0]  comp_reg [vt4_pkg::MAT_DIM];

    // exact row sums, then clamp to the data width
    always_comb begin
        for (int r = 0; r < vt4_pkg::MAT_DIM; r++) begin
            row_sum[r] = '0;
            for (int c = 0; c < vt4_pkg::MAT_DIM; c++) begin
                row_sum[r] = row_sum[r] + SUM_W'(term[r][c]);
            end
            head[r] = row_sum[r][SUM_W-1:DATA_WIDTH-1];
            sat_hit[r] = !((&head[r]) || !(|head[r]));
            if (!sat_hit[r]) begin
                sat_val[r] = row_sum[r][DATA_WIDTH-1:0];
            end else if (row_sum[r][SUM_W-1]) begin
                sat_val[r] = {1'b1, {(DATA_WIDTH-1){1'b0}}};
            end else begin
                sat_val[r] = {1'b0, {(DATA_WIDTH-1){1'b1}}};
            end
            comp_next[r] = vt4_pkg::FIELD_W'(sat_val[r]);
        end
        // points report no w and its saturation does not count
        if (!ctrl.has_w) begin
            comp_next[vt4_pkg::MAT_DIM-1] = '0;
        end
        ovf_next = (|sat_hit[vt4_pkg::MAT_DIM-2:0])
                 || (ctrl.has_w && sat_hit[vt4_pkg::MAT_DIM-1]);
    end

    // result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load_en) begin
            valid_reg <= ctrl.valid;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (load_en && ctrl.valid) begin
            comp_reg  <= comp_next;
            has_w_reg <= ctrl.has_w;
            ovf_reg   <= ovf_next;
        end
    end

    assign out_valid    = valid_reg;
    assign out_comp     = comp_reg;
    assign out_has_w    = has_w_reg;
    assign out_overflow = ovf_reg;

endmodule

// ----- hw/rtl/vertex_transform_4x4.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_transform_4x4
// 4x4 matrix times vector in signed fixed point, with coefficient loads.
// ----------------------------------------------------------------------------
//  channel   prefix  direction  payload
//  input     s_      in         action, coeff_index, coeff_value, in_x..in_w
//  result    m_      out        out_x..out_w, has_w, overflow
//
//  one item per cycle sustained while m_ready holds; a transform's result
//  passes the input register, product register and result register in turn
//  before it is presented on the result channel.
//  loads write the coefficient as they leave the input register, give no
//  result and never stall. aresetn clears the valid flags and the matrix.
//  a stall on m_ready backs up through the three stages to s_ready.
// ----------------------------------------------------------------------------
module vertex_transform_4x4 #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // input channel
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [vt4_pkg::ACTION_W-1:0]       s_action,
    input  logic [vt4_pkg::COEFF_IDX_W-1:0]    s_coeff_index,
    input  logic signed [vt4_pkg::FIELD_W-1:0] s_coeff_value,
    input  logic signed [vt4_pkg::FIELD_W-1:0] s_in_x,
    input  logic signed [vt4_pkg::FIELD_W-1:0] s_in_y,
    input  logic signed [vt4_pkg::FIELD_W-1:0] s_in_z,
    input  logic signed [vt4_pkg::FIELD_W-1:0] s_in_w,
    // result channel
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [vt4_pkg::FIELD_W-1:0] m_out_x,
    output logic signed [vt4_pkg::FIELD_W-1:0] m_out_y,
    output logic signed [vt4_pkg::FIELD_W-1:0] m_out_z,
    output logic signed [vt4_pkg::FIELD_W-1:0] m_out_w,
    output logic                               m_has_w,
    output logic                               m_overflow
);

    logic                                 in_valid_reg;
    vt4_pkg::action_t                     in_action_reg;
    logic [vt4_pkg::COEFF_IDX_W-1:0]      in_idx_reg;
    logic signed [DATA_WIDTH-1:0]         in_coeff_reg;
    logic signed [DATA_WIDTH-1:0]         in_vec_reg [vt4_pkg::MAT_DIM];

    logic                                 is_load;
    logic                                 is_point;
    logic                                 is_xform;
    logic                                 out_load_ok;
    logic                                 prod_ok;
    logic                                 in_leave;
    logic                                 s_xfer;

    logic signed [DATA_WIDTH-1:0]         coeff [vt4_pkg::NUM_COEFFS];
    vt4_pkg::stage_ctrl_t                 prod_ctrl;
    logic signed [2*DATA_WIDTH-1:0]       term [vt4_pkg::MAT_DIM][vt4_pkg::MAT_DIM];
    logic [vt4_pkg::FIELD_W-1:0]          out_comp [vt4_pkg::MAT_DIM];

    // action decode of the held item
    always_comb begin
        is_load  = 1'b0;
        is_point = 1'b0;
        is_xform = 1'b0;
        unique case (in_action_reg)
            vt4_pkg::ACT_LOAD: begin
                is_load = 1'b1;
            end
            vt4_pkg::ACT_POINT: begin
                is_point = 1'b1;
                is_xform = 1'b1;
            end
            vt4_pkg::ACT_VECTOR: begin
                is_xform = 1'b1;
            end
            default: begin
                is_xform = 1'b0;
            end
        endcase
    end

    // stage flow control
    assign out_load_ok = !m_valid || m_ready;
    assign prod_ok     = !prod_ctrl.valid || out_load_ok;
    assign in_leave    = in_valid_reg && (!is_xform || prod_ok);
    assign s_ready     = !in_valid_reg || in_leave;
    assign s_xfer      = s_valid && s_ready;

    // input register valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    // input register payload, fields taken as data-width two's complement
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            in_action_reg  <= vt4_pkg::action_t'(s_action);
            in_idx_reg     <= s_coeff_index;
            in_coeff_reg   <= DATA_WIDTH'($unsigned(s_coeff_value));
            in_vec_reg[0]  <= DATA_WIDTH'($unsigned(s_in_x));
            in_vec_reg[1]  <= DATA_WIDTH'($unsigned(s_in_y));
            in_vec_reg[2]  <= DATA_WIDTH'($unsigned(s_in_z));
            in_vec_reg[3]  <= DATA_WIDTH'($unsigned(s_in_w));
        end
    end

    // matrix storage
    vt4_coeff_bank #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_coeff_bank (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (in_valid_reg && is_load),
        .wr_idx  (in_idx_reg),
        .wr_data (in_coeff_reg),
        .coeff   (coeff)
    );

    // products
    vt4_product_stage #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_product_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load_en  (prod_ok),
        .in_xform (in_valid_reg && is_xform),
        .in_point (is_point),
        .vec      (in_vec_reg),
        .coeff    (coeff),
        .ctrl     (prod_ctrl),
        .term     (term)
    );

    // sums, saturation and result register
    vt4_accum_stage #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_accum_stage (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .load_en      (out_load_ok),
        .ctrl         (prod_ctrl),
        .term         (term),
        .out_valid    (m_valid),
        .out_comp     (out_comp),
        .out_has_w    (m_has_w),
        .out_overflow (m_overflow)
    );

    assign m_out_x = out_comp[0];
    assign m_out_y = out_comp[1];
    assign m_out_z = out_comp[2];
    assign m_out_w = out_comp[3];

    // a point result never carries a w component
    a_point_w_zero : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_has_w) |-> (m_out_w == '0))
        else $error("point result with nonzero w");

    // the product stage only fills from a held transform
    a_prod_from_xform : assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(prod_ctrl.valid) |-> $past(in_valid_reg && is_xform))
        else $error("product stage filled without a transform");

    // a full product stage holds while the result register is stalled
    a_prod_hold : assert property (@(posedge aclk) disable iff (!aresetn)
        (prod_ctrl.valid && m_valid && !m_ready) |=> prod_ctrl.valid)
        else $error("product stage dropped an item under stall");

    // input side only refuses while an item is held
    a_ready_low : assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && is_xform && prod_ctrl.valid && m_valid))
        else $error("input not ready without a full pipeline");

endmodule

// ----- bench/tb_vertex_transform_4x4.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_vertex_transform_4x4
// Self-checking bench for the 4x4 fixed-point vertex transform. Coefficient
// loads, point and four-vector transforms and unused action codes are driven
// over the input channel. A scoreboard keeps its own copy of the matrix,
// predicts every transform in Q16.16 with floored products and saturated
// sums, and compares each result transfer field by field. Both channels idle
// at random, and one long output stall backs the pipeline up to s_ready.
// ----------------------------------------------------------------------------
module tb_vertex_transform_4x4;

    localparam int     FRAC        = 16;
    localparam longint COMP_MAX    = 64'sd2147483647;
    localparam longint COMP_MIN    = -64'sd2147483648;
    localparam logic [vt4_pkg::ACTION_W-1:0] ACT_UNUSED = 2'd3;
    localparam logic signed [vt4_pkg::FIELD_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [vt4_pkg::FIELD_W-1:0] Q_MIN = 32'sh8000_0000;
    localparam logic signed [vt4_pkg::FIELD_W-1:0] Q_ONE = 32'sh0001_0000;
    localparam int     RANDOM_ITEMS = 400;
    localparam int     LONG_STALL   = 250;
    localparam int     DRAIN_LIMIT  = 5000;
    localparam int     CYCLE_LIMIT  = 200000;

    typedef struct {
        logic [vt4_pkg::ACTION_W-1:0]        action;
        logic [vt4_pkg::COEFF_IDX_W-1:0]     coeff_index;
        logic signed [vt4_pkg::FIELD_W-1:0]  coeff_value;
        logic signed [vt4_pkg::FIELD_W-1:0]  in_x;
        logic signed [vt4_pkg::FIELD_W-1:0]  in_y;
        logic signed [vt4_pkg::FIELD_W-1:0]  in_z;
        logic signed [vt4_pkg::FIELD_W-1:0]  in_w;
    } vt_item_t;

    typedef struct {
        logic signed [vt4_pkg::FIELD_W-1:0]  out_x;
        logic signed [vt4_pkg::FIELD_W-1:0]  out_y;
        logic signed [vt4_pkg::FIELD_W-1:0]  out_z;
        logic signed [vt4_pkg::FIELD_W-1:0]  out_w;
        logic                                has_w;
        logic                                overflow;
    } vt_result_t;

    // matrix copy, transform predictor and queue of pending results
    class transform_scoreboard;
        logic signed [vt4_pkg::FIELD_W-1:0] matrix [vt4_pkg::NUM_COEFFS];
        vt_result_t pending [$];
        int errors;
        int loads;
        int points;
        int vectors;
        int unused;
        int checked;
        int saturated;

        function new();
            foreach (matrix[i]) matrix[i] = '0;
        endfunction

        // exact product, floored by the fraction shift
        function longint scaled_product(logic signed [vt4_pkg::FIELD_W-1:0] a,
                                        logic signed [vt4_pkg::FIELD_W-1:0] b);
            longint p;
            p = longint'(a) * longint'(b);
            return p >>> FRAC;
        endfunction

        function logic signed [vt4_pkg::FIELD_W-1:0] clamp(longint acc, inout bit sat);
            if (acc > COMP_MAX) begin
                sat = 1'b1;
                return Q_MAX;
            end
            if (acc < COMP_MIN) begin
                sat = 1'b1;
                return Q_MIN;
            end
            return acc[vt4_pkg::FIELD_W-1:0];
        endfunction

        function void note_input(vt_item_t it);
            logic signed [vt4_pkg::FIELD_W-1:0] vec [vt4_pkg::MAT_DIM];
            logic signed [vt4_pkg::FIELD_W-1:0] comp [vt4_pkg::MAT_DIM];
            vt_result_t res;
            longint acc;
            int rows;
            bit sat;
            if (it.action == vt4_pkg::ACT_LOAD) begin
                matrix[it.coeff_index] = it.coeff_value;
                loads++;
                return;
            end
            if (it.action != vt4_pkg::ACT_POINT && it.action != vt4_pkg::ACT_VECTOR) begin
                unused++;
                return;
            end
            vec = '{it.in_x, it.in_y, it.in_z, it.in_w};
            comp = '{default: '0};
            sat = 1'b0;
            rows = (it.action == vt4_pkg::ACT_POINT) ? 3 : vt4_pkg::MAT_DIM;
            for (int r = 0; r < rows; r++) begin
                acc = 0;
                for (int c = 0; c < 3; c++)
                    acc += scaled_product(matrix[c*vt4_pkg::MAT_DIM + r], vec[c]);
                // points take column three as a plain translation
                if (it.action == vt4_pkg::ACT_POINT)
                    acc += longint'(matrix[3*vt4_pkg::MAT_DIM + r]);
                else
                    acc += scaled_product(matrix[3*vt4_pkg::MAT_DIM + r], vec[3]);
                comp[r] = clamp(acc, sat);
            end
            res.out_x    = comp[0];
            res.out_y    = comp[1];
            res.out_z    = comp[2];
            res.out_w    = comp[3];
            res.has_w    = (it.action == vt4_pkg::ACT_VECTOR);
            res.overflow = sat;
            if (it.action == vt4_pkg::ACT_POINT) points++;
            else vectors++;
            if (sat) saturated++;
            pending.push_back(res);
        endfunction

        function void check_result(vt_result_t got);
            vt_result_t exp_res;
            if (pending.size() == 0) begin
                $error("result transfer with nothing expected: out_x %0d", got.out_x);
                errors++;
                return;
            end
            exp_res = pending.pop_front();
            checked++;
            if (got.out_x !== exp_res.out_x) begin
                $error("out_x: expected %0d, actual %0d", exp_res.out_x, got.out_x);
                errors++;
            end
            if (got.out_y !== exp_res.out_y) begin
                $error("out_y: expected %0d, actual %0d", exp_res.out_y, got.out_y);
                errors++;
            end
            if (got.out_z !== exp_res.out_z) begin
                $error("out_z: expected %0d, actual %0d", exp_res.out_z, got.out_z);
                errors++;
            end
            if (got.out_w !== exp_res.out_w) begin
                $error("out_w: expected %0d, actual %0d", exp_res.out_w, got.out_w);
                errors++;
            end
            if (got.has_w !== exp_res.has_w) begin
                $error("has_w: expected %0d, actual %0d", exp_res.has_w, got.has_w);
                errors++;
            end
            if (got.overflow !== exp_res.overflow) begin
                $error("overflow: expected %0d, actual %0d", exp_res.overflow, got.overflow);
                errors++;
            end
        endfunction
    endclass

    logic                                aclk = 1'b0;
    logic                                aresetn = 1'b0;
    logic                                s_valid = 1'b0;
    logic                                s_ready;
    logic [vt4_pkg::ACTION_W-1:0]        s_action = vt4_pkg::ACT_LOAD;
    logic [vt4_pkg::COEFF_IDX_W-1:0]     s_coeff_index = '0;
    logic signed [vt4_pkg::FIELD_W-1:0]  s_coeff_value = '0;
    logic signed [vt4_pkg::FIELD_W-1:0]  s_in_x = '0;
    logic signed [vt4_pkg::FIELD_W-1:0]  s_in_y = '0;
    logic signed [vt4_pkg::FIELD_W-1:0]  s_in_z = '0;
    logic signed [vt4_pkg::FIELD_W-1:0]  s_in_w = '0;
    logic                                m_valid;
    logic                                m_ready = 1'b0;
    logic signed [vt4_pkg::FIELD_W-1:0]  m_out_x;
    logic signed [vt4_pkg::FIELD_W-1:0]  m_out_y;
    logic signed [vt4_pkg::FIELD_W-1:0]  m_out_z;
    logic signed [vt4_pkg::FIELD_W-1:0]  m_out_w;
    logic                                m_has_w;
    logic                                m_overflow;

    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;
    bit hold_request = 1'b0;
    int cycle_count = 0;
    int long_stalls = 0;

    transform_scoreboard sb = new();

    vertex_transform_4x4 DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_coeff_index (s_coeff_index),
        .s_coeff_value (s_coeff_value),
        .s_in_x        (s_in_x),
        .s_in_y        (s_in_y),
        .s_in_z        (s_in_z),
        .s_in_w        (s_in_w),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_x       (m_out_x),
        .m_out_y       (m_out_y),
        .m_out_z       (m_out_z),
        .m_out_w       (m_out_w),
        .m_has_w       (m_has_w),
        .m_overflow    (m_overflow)
    );

    // clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // input transfers feed the predictor
    always @(posedge aclk) begin
        vt_item_t it;
        if (aresetn && s_valid && s_ready) begin
            it.action      = s_action;
            it.coeff_index = s_coeff_index;
            it.coeff_value = s_coeff_value;
            it.in_x        = s_in_x;
            it.in_y        = s_in_y;
            it.in_z        = s_in_z;
            it.in_w        = s_in_w;
            sb.note_input(it);
        end
    end

    // result transfers go to the checker
    always @(posedge aclk) begin
        vt_result_t got;
        if (aresetn && m_valid && m_ready) begin
            got.out_x    = m_out_x;
            got.out_y    = m_out_y;
            got.out_z    = m_out_z;
            got.out_w    = m_out_w;
            got.has_w    = m_has_w;
            got.overflow = m_overflow;
            sb.check_result(got);
        end
    end

    // receiver: ready bursts, random stalls and one long hold-off
    initial begin
        forever begin
            if (hold_request) begin
                m_ready <= 1'b0;
                repeat (LONG_STALL) @(posedge aclk);
                hold_request = 1'b0;
                long_stalls++;
            end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge aclk);
            end
        end
    end

    // offer one item and hold it until the transfer, then maybe idle
    task automatic send_item(input vt_item_t it);
        s_valid       <= 1'b1;
        s_action      <= it.action;
        s_coeff_index <= it.coeff_index;
        s_coeff_value <= it.coeff_value;
        s_in_x        <= it.in_x;
        s_in_y        <= it.in_y;
        s_in_z        <= it.in_z;
        s_in_w        <= it.in_w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (tx_idle_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
    endtask

    // small values half the time, with extremes, zero and full-range noise
    function automatic logic signed [vt4_pkg::FIELD_W-1:0] rand_q();
        case ($urandom_range(0, 9))
            0: return Q_MAX;
            1: return Q_MIN;
            2: return '0;
            3, 4: return $urandom;
            default: return $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
        endcase
    endfunction

    // random filler in every field, then the meaningful ones set by the caller
    function automatic vt_item_t noise_item(logic [vt4_pkg::ACTION_W-1:0] act);
        vt_item_t it;
        it.action      = act;
        it.coeff_index = vt4_pkg::COEFF_IDX_W'($urandom);
        it.coeff_value = $urandom;
        it.in_x        = $urandom;
        it.in_y        = $urandom;
        it.in_z        = $urandom;
        it.in_w        = $urandom;
        return it;
    endfunction

    task automatic send_load(input int idx,
                             input logic signed [vt4_pkg::FIELD_W-1:0] val);
        vt_item_t it;
        it = noise_item(vt4_pkg::ACT_LOAD);
        it.coeff_index = vt4_pkg::COEFF_IDX_W'(idx);
        it.coeff_value = val;
        send_item(it);
    endtask

    task automatic send_xform(input logic [vt4_pkg::ACTION_W-1:0] act,
                              input logic signed [vt4_pkg::FIELD_W-1:0] x,
                              input logic signed [vt4_pkg::FIELD_W-1:0] y,
                              input logic signed [vt4_pkg::FIELD_W-1:0] z,
                              input logic signed [vt4_pkg::FIELD_W-1:0] w);
        vt_item_t it;
        it = noise_item(act);
        it.in_x = x;
        it.in_y = y;
        it.in_z = z;
        it.in_w = w;
        send_item(it);
    endtask

    initial begin
        int count;
        int sel;
        int drain;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: zero matrix after reset, unused action
        send_xform(vt4_pkg::ACT_VECTOR, Q_MAX, Q_MIN, Q_MAX, Q_MIN);
        send_xform(vt4_pkg::ACT_POINT, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
        send_item(noise_item(ACT_UNUSED));

        // identity diagonal, then values must pass through exactly
        send_load(0, Q_ONE);
        send_load(5, Q_ONE);
        send_load(10, Q_ONE);
        send_load(15, Q_ONE);
        send_xform(vt4_pkg::ACT_VECTOR, Q_MAX, Q_MIN, -32'sd1, 32'sd1);

        // translation at the extremes: saturation high and low
        send_load(12, Q_MAX);
        send_load(13, Q_MIN);
        send_load(14, Q_ONE);
        send_xform(vt4_pkg::ACT_POINT, Q_MAX, Q_MIN, 32'sd5, Q_MAX);
        send_xform(vt4_pkg::ACT_POINT, -32'sd1, 32'sd1, '0, '0);
        send_xform(vt4_pkg::ACT_VECTOR, Q_MAX, Q_MIN, 32'sd5, '0);

        // most negative coefficient times most negative input
        send_load(0, Q_MIN);
        send_xform(vt4_pkg::ACT_POINT, Q_MIN, '0, '0, '0);

        // tiny coefficient floors a negative product
        send_load(1, 32'sd1);
        send_xform(vt4_pkg::ACT_VECTOR, -32'sd1, '0, '0, '0);
        send_load(15, Q_MAX);
        send_xform(vt4_pkg::ACT_VECTOR, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
        send_item(noise_item(ACT_UNUSED));

        // random part with idling, one long stall, then a flat-out tail
        count = 0;
        while (count < RANDOM_ITEMS) begin
            if (count >= 150 && !hold_request && long_stalls == 0) begin
                tx_idle_on = 1'b0;
                hold_request = 1'b1;
            end else if (count >= 210 && count < 330) begin
                tx_idle_on = 1'b1;
            end else if (count >= 330) begin
                tx_idle_on = 1'b0;
                rx_idle_on = 1'b0;
            end
            sel = $urandom_range(0, 99);
            if (sel < 3) begin
                // full matrix reload, column by column
                for (int i = 0; i < vt4_pkg::NUM_COEFFS; i++)
                    send_load(i, rand_q());
                count += vt4_pkg::NUM_COEFFS;
            end else if (sel < 20) begin
                send_load($urandom_range(0, vt4_pkg::NUM_COEFFS - 1), rand_q());
                count++;
            end else if (sel < 96) begin
                send_xform((sel < 58) ? vt4_pkg::ACT_POINT : vt4_pkg::ACT_VECTOR,
                           rand_q(), rand_q(), rand_q(), rand_q());
                count++;
            end else begin
                send_item(noise_item(ACT_UNUSED));
            end
        end
        s_valid <= 1'b0;

        // drain the pipeline
        drain = 0;
        while (sb.pending.size() != 0 && drain < DRAIN_LIMIT) begin
            @(posedge aclk);
            drain++;
        end
        repeat (8) @(posedge aclk);
        if (sb.pending.size() != 0) begin
            $error("%0d expected results never arrived", sb.pending.size());
            sb.errors++;
        end

        $display("sent %0d loads, %0d point and %0d vector transforms, %0d unused codes",
                 sb.loads, sb.points, sb.vectors, sb.unused);
        $display("checked %0d results (%0d saturated) across %0d long output stall(s)",
                 sb.checked, sb.saturated, long_stalls);
        if (sb.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
